>>> src/hng_pkg.sv
// ----------------------------------------------------------------------------
// hng_pkg
// Shared types and constants of the height-map normal generator.
// ----------------------------------------------------------------------------
package hng_pkg;

  // Configuration register indexes.
  localparam logic CfgFrameColumns = 1'b0;
  localparam logic CfgFrameRows    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [10:0] FrameColumnsReset = 11'd1024;
  localparam logic [15:0] FrameRowsReset    = 16'd256;

  // Item kinds.
  localparam logic KindSample = 1'b0;
  localparam logic KindDrain  = 1'b1;

  // Square of the constant z term, 2.0 in Q8.8 (512 * 512).
  localparam logic [31:0] ZSquare = 32'd262144;

  // Width of the accumulators in the normalizing unit.
  localparam int AccW = 68;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic        [14:0] nz;
  } normal_t;

  typedef struct packed {
    logic               start;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } norm_req_t;

endpackage

>>> src/heightmap_normal_generator.sv
// ----------------------------------------------------------------------------
// heightmap_normal_generator
// Central-difference normal generator over a raster height map, one row late.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                   Payload
// config    in         cfg_we_i                    cfg_addr_i, cfg_data_i
// input     in         in_valid_i / in_stall_o     item_kind_i, height_sample_i
// output    out        out_valid_o / out_stall_i   out_column_o .. frame_end_o
//
// An ignored item is dropped in the idle state, and a sample that yields no
// result also passes the three read states. An item with a result then waits
// on the shared normalizer, which squares the two differences on one multiplier
// and then resolves 15 bits for each of the three components, one at a time.
// Reset clears the counters and the drain flag; the line stores are not
// cleared, since no entry is used in a result before it is written.
// The output register lets the next item start while a result waits; input is
// held while busy, and longer while a new result waits on a stalled old one.
//
module heightmap_normal_generator #(
  parameter int MAX_COLUMNS = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               item_kind_i,
  input  logic [15:0]        height_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [9:0]         out_column_o,
  output logic [15:0]        out_row_o,
  output logic [15:0]        out_height_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic [14:0]        normal_z_o,
  output logic               frame_end_o
);
  import hng_pkg::*;

  localparam int ColW = $clog2(MAX_COLUMNS);
  localparam logic [15:0] HeightMask =
    (HEIGHT_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << HEIGHT_BITS) - 32'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_CALC,
    S_WAIT,
    S_LOAD
  } state_e;

  state_e       state_q;
  logic [10:0]  frame_cols_q;
  logic [15:0]  frame_rows_q;
  logic [ColW-1:0] col_q;
  logic [15:0]  row_q;
  logic         draining_q;
  logic [15:0]  prev_sample_q;
  logic         kind_q;
  logic [15:0]  sample_q;
  logic [15:0]  centre_q, older_q;
  logic [ColW-1:0] pix_col_q;
  logic [15:0]  pix_row_q;
  logic         last_q;
  norm_req_t    req_q;
  logic         out_valid_q;
  logic [9:0]   out_col_q;
  logic [15:0]  out_row_q, out_height_q;
  normal_t      out_norm_q;
  logic         out_end_q;

  logic [31:0]  cols_eff, rows_eff;
  logic         row_end;
  logic         has_right;
  logic [ColW-1:0] raddr_newer, raddr_older;
  logic [15:0]  newer_rdata, older_rdata;
  logic         line_we;
  logic [15:0]  right_val, left_val, prev_val, next_val;
  logic         norm_done;
  normal_t      norm_res;
  logic         out_free;

  // Effective frame size: zero counts as one, columns saturate at the store.
  always_comb begin
    if (frame_cols_q == 11'd0) begin
      cols_eff = 32'd1;
    end else if (32'(frame_cols_q) > 32'(MAX_COLUMNS)) begin
      cols_eff = 32'(MAX_COLUMNS);
    end else begin
      cols_eff = 32'(frame_cols_q);
    end
    rows_eff = (frame_rows_q == 16'd0) ? 32'd1 : 32'(frame_rows_q);
  end

  assign row_end   = (32'(col_q) + 32'd1) >= cols_eff;
  assign has_right = !row_end;

  // The first read fetches the centre and the row above; the second fetches
  // the right neighbour from the same row store.
  assign raddr_older = col_q;
  assign raddr_newer = (state_q == S_RD1 && has_right) ? col_q + ColW'(1) : col_q;
  assign line_we     = (state_q == S_RD2) && (kind_q == KindSample);

  hng_ram #(.WIDTH(16), .DEPTH(MAX_COLUMNS)) u_newer_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (col_q),
    .wdata_i (sample_q),
    .raddr_i (raddr_newer),
    .rdata_o (newer_rdata)
  );

  hng_ram #(.WIDTH(16), .DEPTH(MAX_COLUMNS)) u_older_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (col_q),
    .wdata_i (centre_q),
    .raddr_i (raddr_older),
    .rdata_o (older_rdata)
  );

  // Neighbours outside the frame fall back to the centre sample.
  always_comb begin
    right_val = has_right ? newer_rdata : centre_q;
    left_val  = (col_q == '0) ? centre_q : prev_sample_q;
    if (kind_q == KindDrain) begin
      prev_val = (row_q == 16'd0) ? centre_q : older_q;
      next_val = centre_q;
    end else begin
      prev_val = (row_q == 16'd1) ? centre_q : older_q;
      next_val = sample_q;
    end
  end

  hng_norm_unit u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_q),
    .done_o   (norm_done),
    .result_o (norm_res)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cols_q <= FrameColumnsReset;
      frame_rows_q <= FrameRowsReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgFrameColumns: frame_cols_q <= cfg_data_i[10:0];
        CfgFrameRows:    frame_rows_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      col_q         <= '0;
      row_q         <= '0;
      draining_q    <= 1'b0;
      prev_sample_q <= '0;
      req_q.start   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      req_q.start <= (state_q == S_CALC);
      // A result taken while a new one loads is replaced in the load state.
      if (out_valid_q && !out_stall_i && (state_q != S_LOAD)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q   <= item_kind_i;
            sample_q <= height_sample_i & HeightMask;
            // A drain tick outside draining and a sample during draining
            // are dropped here.
            if ((item_kind_i == KindDrain) == draining_q) begin
              state_q <= S_RD0;
            end
          end
        end
        S_RD0: state_q <= S_RD1;
        S_RD1: begin
          centre_q <= newer_rdata;
          older_q  <= older_rdata;
          state_q  <= S_RD2;
        end
        S_RD2: begin
          req_q.dx      <= $signed({1'b0, left_val}) - $signed({1'b0, right_val});
          req_q.dy      <= $signed({1'b0, prev_val}) - $signed({1'b0, next_val});
          pix_col_q     <= col_q;
          prev_sample_q <= centre_q;
          if (kind_q == KindDrain) begin
            pix_row_q <= row_q;
            last_q    <= row_end;
            state_q   <= S_CALC;
            if (row_end) begin
              draining_q <= 1'b0;
              col_q      <= '0;
              row_q      <= '0;
            end else begin
              col_q <= col_q + ColW'(1);
            end
          end else begin
            pix_row_q <= row_q - 16'd1;
            last_q    <= 1'b0;
            state_q   <= (row_q != 16'd0) ? S_CALC : S_IDLE;
            if (row_end) begin
              col_q <= '0;
              if ((32'(row_q) + 32'd1) >= rows_eff) begin
                draining_q <= 1'b1;
              end else begin
                row_q <= row_q + 16'd1;
              end
            end else begin
              col_q <= col_q + ColW'(1);
            end
          end
        end
        S_CALC: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (norm_done) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_col_q    <= 10'(pix_col_q);
            out_row_q    <= pix_row_q;
            out_height_q <= centre_q;
            out_norm_q   <= norm_res;
            out_end_q    <= last_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_column_o = out_col_q;
  assign out_row_o    = out_row_q;
  assign out_height_o = out_height_q;
  assign normal_x_o   = out_norm_q.nx;
  assign normal_y_o   = out_norm_q.ny;
  assign normal_z_o   = out_norm_q.nz;
  assign frame_end_o  = out_end_q;

endmodule

>>> src/hng_ram.sv
// ----------------------------------------------------------------------------
// hng_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hng_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/hng_norm_unit.sv
// ----------------------------------------------------------------------------
// hng_norm_unit
// Iterative normalizer: squares the differences on one multiplier, then
// resolves each Q1.14 component one bit at a time by a shift-add compare.
// ----------------------------------------------------------------------------
module hng_norm_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hng_pkg::norm_req_t req_i,
  output logic               done_o,
  output hng_pkg::normal_t   result_o
);
  import hng_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SUM,
    S_STEPA,
    S_STEPB
  } state_e;

  state_e            state_q;
  logic [15:0]       ax_q, ay_q;
  logic              negx_q, negy_q;
  logic [31:0]       a2x_q, a2y_q;
  logic [33:0]       s_q;
  logic [1:0]        comp_q;
  logic [3:0]        k_q;
  logic [14:0]       q_q;
  logic [AccW-1:0]   q2s_q, qs_q, c2s_q, cs_q;
  logic              done_q;
  normal_t           res_q;

  logic [16:0]       abs_dx, abs_dy;
  logic [15:0]       mul_op;
  logic [31:0]       prod;
  logic [31:0]       a2_sel;
  logic [AccW-1:0]   limit;
  logic [AccW-1:0]   c2s_d, cs_d, t2s;
  logic [14:0]       bitv;
  logic              take;

  assign abs_dx = req_i.dx[16] ? (~req_i.dx + 17'd1) : req_i.dx;
  assign abs_dy = req_i.dy[16] ? (~req_i.dy + 17'd1) : req_i.dy;

  assign mul_op = (state_q == S_SQX) ? ax_q : ay_q;
  assign prod   = mul_op * mul_op;

  always_comb begin
    case (comp_q)
      2'd0:    a2_sel = a2x_q;
      2'd1:    a2_sel = a2y_q;
      default: a2_sel = ZSquare;
    endcase
  end

  assign limit = AccW'(a2_sel) << 30;
  assign bitv  = 15'd1 << k_q;

  // With c = q + bit: c*c*S = q*q*S + 2*bit*q*S + bit*bit*S.
  assign c2s_d = q2s_q + (qs_q << (5'(k_q) + 5'd1))
               + (AccW'(s_q) << {k_q, 1'b0});
  assign cs_d  = qs_q + (AccW'(s_q) << k_q);
  // (2c - 1)^2 * S
  assign t2s   = (c2s_q << 2) - (cs_q << 2) + AccW'(s_q);
  assign take  = !(q_q[14] && (k_q != 4'd14)) && (t2s <= limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      comp_q  <= 2'd0;
      k_q     <= 4'd14;
    end else begin
      done_q <= (state_q == S_STEPB) && (k_q == 4'd0) && (comp_q == 2'd2);
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            ax_q    <= abs_dx[15:0];
            ay_q    <= abs_dy[15:0];
            negx_q  <= req_i.dx[16];
            negy_q  <= req_i.dy[16];
            state_q <= S_SQX;
          end
        end
        S_SQX: begin
          a2x_q   <= prod;
          state_q <= S_SQY;
        end
        S_SQY: begin
          a2y_q   <= prod;
          state_q <= S_SUM;
        end
        S_SUM: begin
          s_q     <= 34'(a2x_q) + 34'(a2y_q) + 34'(ZSquare);
          comp_q  <= 2'd0;
          k_q     <= 4'd14;
          q_q     <= '0;
          q2s_q   <= '0;
          qs_q    <= '0;
          state_q <= S_STEPA;
        end
        S_STEPA: begin
          c2s_q   <= c2s_d;
          cs_q    <= cs_d;
          state_q <= S_STEPB;
        end
        S_STEPB: begin
          logic [14:0] q_new;
          q_new = take ? (q_q | bitv) : q_q;
          if (take && (k_q != 4'd0)) begin
            q_q   <= q_new;
            q2s_q <= c2s_q;
            qs_q  <= cs_q;
          end
          if (k_q == 4'd0) begin
            case (comp_q)
              2'd0:    res_q.nx <= negx_q ? -$signed({1'b0, q_new}) : $signed({1'b0, q_new});
              2'd1:    res_q.ny <= negy_q ? -$signed({1'b0, q_new}) : $signed({1'b0, q_new});
              default: res_q.nz <= q_new;
            endcase
            q_q   <= '0;
            q2s_q <= '0;
            qs_q  <= '0;
            k_q   <= 4'd14;
            if (comp_q == 2'd2) begin
              state_q <= S_IDLE;
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= S_STEPA;
            end
          end else begin
            k_q     <= k_q - 4'd1;
            state_q <= S_STEPA;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
